// ----- hw/rtl/ngh_pkg.sv -----
// Shared types and constants of the noise gate with hold and gain envelope.
// Used by the register file, the controller, the datapath and the top level.
package ngh_pkg;

  // Register map: one 32-bit word per register.
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_ATTACK    = 2'd1;
  localparam logic [IDX_W-1:0] REG_RELEASE   = 2'd2;
  localparam logic [IDX_W-1:0] REG_HOLD      = 2'd3;

  localparam int unsigned THRESH_W = 16;
  localparam int unsigned HOLD_W   = 24;
  localparam int unsigned QUIET_W  = 25;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_sample;
    logic gate_upd;
    logic mul_env;
    logic env_upd;
    logic mul_out;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/ngh_regs.sv -----
// Configuration register file of the noise gate, on an APB-style port.
// Depends on ngh_pkg for the register map.
module ngh_regs #(
  parameter int unsigned COEF_FRAC_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ngh_pkg::ADDR_W-1:0]          paddr,
  input  logic [ngh_pkg::DATA_W-1:0]          pwdata,
  output logic [ngh_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  output logic [ngh_pkg::THRESH_W-1:0]        threshold_o,
  output logic [COEF_FRAC_BITS:0]             attack_o,
  output logic [COEF_FRAC_BITS:0]             release_o,
  output logic [ngh_pkg::HOLD_W-1:0]          hold_o
);

  localparam int unsigned COEF_W = COEF_FRAC_BITS + 1;

  logic [ngh_pkg::THRESH_W-1:0] threshold_q;
  logic [COEF_W-1:0]            attack_q;
  logic [COEF_W-1:0]            release_q;
  logic [ngh_pkg::HOLD_W-1:0]   hold_q;
  logic [ngh_pkg::IDX_W-1:0]    idx;
  logic                         wr_en;

  assign idx    = paddr[ngh_pkg::IDX_W+1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      attack_q    <= '0;
      release_q   <= '0;
      hold_q      <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ngh_pkg::REG_THRESHOLD: threshold_q <= pwdata[ngh_pkg::THRESH_W-1:0];
        ngh_pkg::REG_ATTACK:    attack_q    <= pwdata[COEF_W-1:0];
        ngh_pkg::REG_RELEASE:   release_q   <= pwdata[COEF_W-1:0];
        ngh_pkg::REG_HOLD:      hold_q      <= pwdata[ngh_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ngh_pkg::REG_THRESHOLD: prdata = ngh_pkg::DATA_W'(threshold_q);
      ngh_pkg::REG_ATTACK:    prdata = ngh_pkg::DATA_W'(attack_q);
      ngh_pkg::REG_RELEASE:   prdata = ngh_pkg::DATA_W'(release_q);
      ngh_pkg::REG_HOLD:      prdata = ngh_pkg::DATA_W'(hold_q);
      default:                prdata = '0;
    endcase
  end

  assign threshold_o = threshold_q;
  assign attack_o    = attack_q;
  assign release_o   = release_q;
  assign hold_o      = hold_q;

endmodule

// ----- hw/rtl/ngh_ctrl.sv -----
// Sequencer of the noise gate: steps one sample through gate update,
// envelope multiply, envelope update, output multiply and output load.
// Depends on ngh_pkg for the command and status structs.
module ngh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ngh_pkg::status_t status_i,
  output ngh_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_GATE    = 6'b000010,
    ST_ENV_MUL = 6'b000100,
    ST_ENV_UPD = 6'b001000,
    ST_OUT_MUL = 6'b010000,
    ST_OUT     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d           = ST_GATE;
        end
      end
      ST_GATE: begin
        cmd_o.gate_upd = 1'b1;
        state_d        = ST_ENV_MUL;
      end
      ST_ENV_MUL: begin
        cmd_o.mul_env = 1'b1;
        state_d       = ST_ENV_UPD;
      end
      ST_ENV_UPD: begin
        cmd_o.env_upd = 1'b1;
        state_d       = ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        cmd_o.mul_out = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // Wait here until the previous result has left the output register.
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/ngh_dpath.sv -----
// Datapath of the noise gate: gate and hold counter, one shared multiplier,
// gain envelope and the output register. Depends on ngh_pkg.
module ngh_dpath #(
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ngh_pkg::cmd_t                 cmd_i,
  output ngh_pkg::status_t              status_o,
  input  logic [ngh_pkg::THRESH_W-1:0]  threshold_i,
  input  logic [COEF_FRAC_BITS:0]       attack_i,
  input  logic [COEF_FRAC_BITS:0]       release_i,
  input  logic [ngh_pkg::HOLD_W-1:0]    hold_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          gate_is_open_o
);

  localparam int unsigned ENV_W  = COEF_FRAC_BITS + 1;
  localparam int unsigned MUL_W  = (ENV_W > SAMPLE_BITS) ? ENV_W : SAMPLE_BITS;
  localparam int unsigned PROD_W = ENV_W + MUL_W;
  localparam int unsigned CMP_W  = (SAMPLE_BITS > ngh_pkg::THRESH_W) ?
                                   SAMPLE_BITS : ngh_pkg::THRESH_W;
  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << COEF_FRAC_BITS;

  logic [SAMPLE_BITS-1:0]       sample_q;
  logic                         gate_open_q;
  logic [ngh_pkg::QUIET_W-1:0]  quiet_q;
  logic [ENV_W-1:0]             env_q;
  logic [PROD_W-1:0]            prod_q;
  logic                         out_valid_q;
  logic [SAMPLE_BITS-1:0]       out_sample_q;
  logic                         out_gate_q;

  logic                         neg;
  logic [SAMPLE_BITS-1:0]       mag;
  logic                         above;
  logic [ENV_W-1:0]             coef_raw;
  logic [ENV_W-1:0]             coef;
  logic [MUL_W-1:0]             mul_b;
  logic [ENV_W-1:0]             prod_env;
  logic [PROD_W-1:0]            prod_up;
  logic [SAMPLE_BITS-1:0]       res;

  // Magnitude of the most negative sample is 2^(SAMPLE_BITS-1), which fits unsigned.
  assign neg   = sample_q[SAMPLE_BITS-1];
  assign mag   = neg ? (~sample_q + SAMPLE_BITS'(1)) : sample_q;
  assign above = CMP_W'(mag) > CMP_W'(threshold_i);

  // Coefficients above one are clamped to exactly one.
  assign coef_raw = gate_open_q ? attack_i : release_i;
  assign coef     = (coef_raw > ENV_ONE) ? ENV_ONE : coef_raw;

  assign mul_b    = cmd_i.mul_env ? MUL_W'(coef) : MUL_W'(mag);
  assign prod_env = ENV_W'(prod_q >> COEF_FRAC_BITS);

  // Negative results are floored: round the magnitude up before negating.
  assign prod_up = prod_q + PROD_W'(ENV_ONE - ENV_W'(1));
  assign res     = neg ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(prod_up >> COEF_FRAC_BITS))
                       : SAMPLE_BITS'(prod_q >> COEF_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= sample_in_i;
    end
    if (cmd_i.mul_env || cmd_i.mul_out) begin
      prod_q <= PROD_W'(env_q) * PROD_W'(mul_b);
    end
    if (cmd_i.out_load) begin
      out_sample_q <= res;
      out_gate_q   <= gate_open_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_open_q <= 1'b0;
      quiet_q     <= '0;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.gate_upd) begin
        if (above) begin
          gate_open_q <= 1'b1;
          quiet_q     <= '0;
        end else begin
          if (quiet_q > ngh_pkg::QUIET_W'(hold_i)) begin
            gate_open_q <= 1'b0;
          end
          if (quiet_q != '1) begin
            quiet_q <= quiet_q + ngh_pkg::QUIET_W'(1);
          end
        end
      end
      if (cmd_i.env_upd) begin
        env_q <= gate_open_q ? (prod_env + (ENV_ONE - coef)) : prod_env;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_sample_q;
  assign gate_is_open_o    = out_gate_q;

endmodule

// ----- hw/rtl/noise_gate_hold_envelope.sv -----
// Noise gate with hold time and a Q1.COEF_FRAC_BITS gain envelope. Each
// accepted sample passes through the sequencer steps, two of which use the
// single shared multiplier (envelope times coefficient, then sample
// magnitude times envelope). A new sample is accepted as soon as
// the previous one has reached the output register, even while that result
// still waits to be taken; the sequence stalls only when a second result is
// ready before the first has left. Coefficient and threshold registers sit
// on the APB-style port and should be written while no sample is in flight.
module noise_gate_hold_envelope #(
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ngh_pkg::ADDR_W-1:0]    paddr,
  input  logic [ngh_pkg::DATA_W-1:0]    pwdata,
  output logic [ngh_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          gate_is_open_o
);

  logic [ngh_pkg::THRESH_W-1:0] threshold;
  logic [COEF_FRAC_BITS:0]      attack;
  logic [COEF_FRAC_BITS:0]      release_c;
  logic [ngh_pkg::HOLD_W-1:0]   hold;
  ngh_pkg::cmd_t                cmd;
  ngh_pkg::status_t             status;

  ngh_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold),
    .attack_o    (attack),
    .release_o   (release_c),
    .hold_o      (hold)
  );

  ngh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ngh_dpath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .threshold_i    (threshold),
    .attack_i       (attack),
    .release_i      (release_c),
    .hold_i         (hold),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_out_o   (sample_out_o),
    .gate_is_open_o (gate_is_open_o)
  );

endmodule
